// ----- rtl/core/port_knock_tracker_macros.svh -----
// Assertion helpers shared by the port knock tracker RTL.
// Every property is sampled on clk_i and is off while rst_ni is low.
`ifndef PORT_KNOCK_TRACKER_MACROS_SVH
`define PORT_KNOCK_TRACKER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PKT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define PKT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/core/pkt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pkt_pkg;

  // Storage sizes.
  localparam int REPLAY_DEPTH = 1024;
  localparam int CLIENT_SLOTS = 16;

  localparam int RIDX_W  = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;
  localparam int RFILL_W = $clog2(REPLAY_DEPTH + 1);
  localparam int CIDX_W  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;

  localparam logic [RFILL_W-1:0] REPLAY_FULL = RFILL_W'(REPLAY_DEPTH);
  localparam logic [CIDX_W-1:0]  CIDX_LAST   = CIDX_W'(CLIENT_SLOTS - 1);

  // Field widths.
  localparam int IP_W   = 32;
  localparam int HEAD_W = 32;
  localparam int TAIL_W = 40;
  localparam int PW_W   = HEAD_W + TAIL_W;
  localparam int EXT_W  = 8;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 16;

  // Sequence digit characters and the extension reset value.
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_ONE  = 8'h31;
  localparam logic [EXT_W-1:0] EXT_RESET = 8'd10;

  // Port codes held in a client slot.
  localparam logic [1:0] CODE_EMPTY = 2'd0;
  localparam logic [1:0] CODE_O     = 2'd1;
  localparam logic [1:0] CODE_G     = 2'd2;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_DIGIT = 3'd1,
    STAT_REPLAY    = 3'd2,
    STAT_NO_SLOT   = 3'd3,
    STAT_CLOSED    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RSCAN,
    ST_RSTORE,
    ST_CSCAN,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    status_e          status;
    logic             start;
    logic [EXT_W-1:0] ext;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/port_knock_tracker.sv -----
// Port knock tracker.
// Knock beats enter on the s_axis channel; tuser selects a knock (0) or a
// server-closed event (1). Each beat gives exactly one result beat on the
// m_axis channel: status, start request and uptime extension.
// A knock walks the replay store one entry per cycle through its single
// registered read port, then walks the client table one entry per cycle.
// A close event or a bad digit skips both walks and goes straight to the
// result. s_axis_tready is high only in the idle state, so a new item is
// taken only once the result of the last one is loaded. The result sits in
// an output register; while the receiver stalls, the next item is still
// accepted and worked on, and it waits for the register to drain before its
// own result is loaded.
// The extension register is written on the cfg channel (always ready); the
// user must write it only while the block is idle; the block does not enforce
// it. Reset empties the replay store, the client table and the start request,
// and loads 10 s into the extension register; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "port_knock_tracker_macros.svh"

module port_knock_tracker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input beats.
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // client_ip[31:0], knock_port[32], password_head[64:33],
  // password_tail[104:65], server_running[105], zero fill above.
  input  wire logic [pkt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation[0].
  input  wire logic                             s_axis_tuser,
  // Result beats.
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // status[2:0], start_server[3], extend_amount[11:4], zero fill above.
  output      logic [pkt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Extension register write channel.
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [pkt_pkg::EXT_W-1:0]        cfg_data_i
);

  pkt_pkg::state_e state_q, state_d;

  // Latched input item.
  logic                          op_q;
  logic [pkt_pkg::IP_W-1:0]      ip_q;
  logic                          port_q;
  logic [pkt_pkg::PW_W-1:0]      pw_q;
  logic                          run_q;

  logic [pkt_pkg::EXT_W-1:0]     ext_q;
  logic                          start_pending_q, start_pending_d;

  // Replay store and its scan.
  logic [pkt_pkg::PW_W-1:0]      replay_mem [pkt_pkg::REPLAY_DEPTH];
  logic [pkt_pkg::RFILL_W-1:0]   replay_fill_q, replay_fill_d;
  logic [pkt_pkg::RFILL_W-1:0]   scan_q, scan_d;
  logic                          rd_en;
  logic                          rd_vld_q, rd_vld_d;
  logic [pkt_pkg::PW_W-1:0]      rd_data_q;
  logic                          wr_en;

  // Client table and its scan.
  logic [pkt_pkg::IP_W-1:0]      peer_addr_q    [pkt_pkg::CLIENT_SLOTS];
  logic                          client_valid_q [pkt_pkg::CLIENT_SLOTS];
  logic [3:0]                    client_codes_q [pkt_pkg::CLIENT_SLOTS];
  logic [pkt_pkg::CIDX_W-1:0]    cidx_q, cidx_d;
  logic                          free_q, free_d;
  logic [pkt_pkg::CIDX_W-1:0]    free_idx_q, free_idx_d;
  logic [pkt_pkg::CIDX_W-1:0]    slot_q, slot_d;
  logic                          alloc_q, alloc_d;
  logic                          tbl_we;
  logic [3:0]                    tbl_codes;

  // Table update terms.
  logic [3:0]                    codes_old;
  logic [3:0]                    codes_new;
  logic [1:0]                    code;
  logic                          complete;
  logic                          entry_hit;

  // Result path.
  pkt_pkg::result_t              res_q, res_d;
  logic                          out_vld_q, out_vld_d;
  logic [pkt_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                          out_load;

  assign s_axis_tready = (state_q == pkt_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Replay reads run only while the scan pointer is below the fill count.
  assign rd_en = (state_q == pkt_pkg::ST_RSCAN) && (scan_q < replay_fill_q);
  assign wr_en = (state_q == pkt_pkg::ST_RSTORE) && (replay_fill_q < pkt_pkg::REPLAY_FULL);

  assign entry_hit = client_valid_q[cidx_q] && (peer_addr_q[cidx_q] == ip_q);

  // New slot contents for the chosen client.
  assign codes_old = alloc_q ? {pkt_pkg::CODE_EMPTY, pkt_pkg::CODE_EMPTY}
                             : client_codes_q[slot_q];
  assign code      = port_q ? pkt_pkg::CODE_G : pkt_pkg::CODE_O;
  assign codes_new = pw_q[pkt_pkg::TAIL_W + 24] ? {code, codes_old[1:0]}
                                                : {codes_old[3:2], code};
  assign complete  = (codes_new[1:0] == pkt_pkg::CODE_G) &&
                     (codes_new[3:2] == pkt_pkg::CODE_O);

  // Sequencer: next state and datapath controls.
  always_comb begin
    state_d         = state_q;
    start_pending_d = start_pending_q;
    replay_fill_d   = replay_fill_q;
    scan_d          = scan_q;
    rd_vld_d        = rd_en;
    cidx_d          = cidx_q;
    free_d          = free_q;
    free_idx_d      = free_idx_q;
    slot_d          = slot_q;
    alloc_d         = alloc_q;
    res_d           = res_q;
    tbl_we          = 1'b0;
    tbl_codes       = codes_new;
    out_load        = 1'b0;
    out_vld_d       = out_vld_q && !m_axis_tready;

    unique case (state_q)
      pkt_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = pkt_pkg::ST_CHECK;
        end
      end
      pkt_pkg::ST_CHECK: begin
        res_d  = '{status: pkt_pkg::STAT_OK, start: 1'b0, ext: '0};
        scan_d = '0;
        if (op_q) begin
          start_pending_d = 1'b0;
          res_d.status    = pkt_pkg::STAT_CLOSED;
          state_d         = pkt_pkg::ST_EMIT;
        end else if (pw_q[pkt_pkg::PW_W-1 -: 8] != pkt_pkg::DIGIT_ZERO &&
                     pw_q[pkt_pkg::PW_W-1 -: 8] != pkt_pkg::DIGIT_ONE) begin
          res_d.status = pkt_pkg::STAT_BAD_DIGIT;
          state_d      = pkt_pkg::ST_EMIT;
        end else begin
          state_d = pkt_pkg::ST_RSCAN;
        end
      end
      pkt_pkg::ST_RSCAN: begin
        // One read issued and one earlier read compared per cycle.
        if (rd_en) begin
          scan_d = scan_q + 1'b1;
        end
        if (rd_vld_q && rd_data_q == pw_q) begin
          res_d.status = pkt_pkg::STAT_REPLAY;
          state_d      = pkt_pkg::ST_EMIT;
        end else if (!rd_en && !rd_vld_q) begin
          state_d = pkt_pkg::ST_RSTORE;
        end
      end
      pkt_pkg::ST_RSTORE: begin
        if (wr_en) begin
          replay_fill_d = replay_fill_q + 1'b1;
        end
        cidx_d  = '0;
        free_d  = 1'b0;
        state_d = pkt_pkg::ST_CSCAN;
      end
      pkt_pkg::ST_CSCAN: begin
        // A known address wins over any free entry seen on the way.
        if (entry_hit) begin
          slot_d  = cidx_q;
          alloc_d = 1'b0;
          state_d = pkt_pkg::ST_UPDATE;
        end else begin
          if (!client_valid_q[cidx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = cidx_q;
          end
          if (cidx_q == pkt_pkg::CIDX_LAST) begin
            if (free_d) begin
              slot_d  = free_idx_d;
              alloc_d = 1'b1;
              state_d = pkt_pkg::ST_UPDATE;
            end else begin
              res_d.status = pkt_pkg::STAT_NO_SLOT;
              state_d      = pkt_pkg::ST_EMIT;
            end
          end else begin
            cidx_d = cidx_q + 1'b1;
          end
        end
      end
      pkt_pkg::ST_UPDATE: begin
        tbl_we = 1'b1;
        if (complete) begin
          tbl_codes = '0;
          if (!start_pending_q && !run_q) begin
            start_pending_d = 1'b1;
            res_d.start     = 1'b1;
          end else begin
            res_d.ext = ext_q;
          end
        end
        state_d = pkt_pkg::ST_EMIT;
      end
      pkt_pkg::ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = pkt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pkt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= pkt_pkg::ST_IDLE;
      start_pending_q <= 1'b0;
      replay_fill_q   <= '0;
      rd_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
      ext_q           <= pkt_pkg::EXT_RESET;
    end else begin
      state_q         <= state_d;
      start_pending_q <= start_pending_d;
      replay_fill_q   <= replay_fill_d;
      rd_vld_q        <= rd_vld_d;
      out_vld_q       <= out_vld_d;
      if (cfg_valid_i) begin
        ext_q <= cfg_data_i;
      end
    end
  end

  // Working registers and the input latch.
  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    cidx_q     <= cidx_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    slot_q     <= slot_d;
    alloc_q    <= alloc_d;
    res_q      <= res_d;
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= s_axis_tuser;
      ip_q   <= s_axis_tdata[31:0];
      port_q <= s_axis_tdata[32];
      pw_q   <= {s_axis_tdata[64:33], s_axis_tdata[104:65]};
      run_q  <= s_axis_tdata[105];
    end
    if (out_load) begin
      out_data_q <= {4'b0000, res_q.ext, res_q.start, res_q.status};
    end
  end

  // Replay store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      replay_mem[replay_fill_q[pkt_pkg::RIDX_W-1:0]] <= pw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= replay_mem[scan_q[pkt_pkg::RIDX_W-1:0]];
    end
  end

  // Client table: valid bits and slot codes clear at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pkt_pkg::CLIENT_SLOTS; i++) begin
        client_valid_q[i] <= 1'b0;
        client_codes_q[i] <= '0;
      end
    end else if (tbl_we) begin
      client_valid_q[slot_q] <= 1'b1;
      client_codes_q[slot_q] <= tbl_codes;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we && alloc_q) begin
      peer_addr_q[slot_q] <= ip_q;
    end
  end

  // Checks on the sequencer and the result path.
  `PKT_ASSERT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready |=> state_q == pkt_pkg::ST_CHECK, "accepted beat did not start work")
  `PKT_ASSERT(a_fill_steps_by_one, replay_fill_q != $past(replay_fill_q) |-> replay_fill_q == $past(replay_fill_q) + 1'b1, "replay fill moved by more than one")
  `PKT_NEVER(a_fill_in_range, replay_fill_q > pkt_pkg::REPLAY_FULL, "replay fill beyond store depth")
  `PKT_ASSERT(a_start_only_ok, m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == pkt_pkg::STAT_OK && m_axis_tdata[11:4] == 8'd0, "start request with a failing status")

endmodule

`default_nettype wire

// ----- sim/port_knock_tracker_tb.sv -----
`timescale 1ns / 1ps

module port_knock_tracker_tb;
  import pkt_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int IDLE_PCT       = 38;
  localparam int PHASE_ITEMS    = 260;
  localparam int STEADY_FIRST   = 60;
  localparam int STEADY_LAST    = 180;
  localparam int HOLDOFF_AT     = 120;
  localparam int HOLDOFF_CYCLES = 3000;
  localparam int SETTLE_CYCLES  = 64;
  localparam longint CYCLE_LIMIT = 64'd6_000_000;
  localparam int IN_PAD = IN_DATA_W - (IP_W + 1 + HEAD_W + TAIL_W + 1);

  // One knock or close beat, as the sender sees it.
  typedef struct packed {
    logic              close;
    logic [IP_W-1:0]   ip;
    logic              port_g;
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
    logic              running;
  } knock_t;

  // A directed beat, with its result typed in where it is obvious.
  typedef struct packed {
    knock_t  beat;
    bit      typed;
    result_t want;
  } script_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // client_ip, knock_port, password_head, password_tail, server_running, zero fill.
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // operation.
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // status, start_server, extend_amount, zero fill.
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [EXT_W-1:0]      cfg_data_i;

  // Mirror of the tracker state.
  logic [PW_W-1:0]  stored_pw[$];
  logic [IP_W-1:0]  peer_addr[CLIENT_SLOTS];
  bit               client_used[CLIENT_SLOTS];
  logic [3:0]       client_codes[CLIENT_SLOTS];
  bit               start_requested;
  logic [EXT_W-1:0] extension_s;

  result_t     results_due[$];
  script_row_t knock_script[$];
  logic [IP_W-1:0] ip_pool[CLIENT_SLOTS];
  logic [PW_W-1:0] last_pw;
  bit          have_last_pw;
  bit          steady;
  bit          holdoff_done = 1'b0;
  int          holdoff_left = 0;
  int          results_seen = 0;
  int          mismatch_count = 0;
  longint      cycle_count;

  port_knock_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Ends the run with a failure once the cycle limit is reached, as when the block stops making progress.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(string what);
    $display("ERROR: result beat %0d: %s", results_seen, what);
    mismatch_count++;
  endtask

  function automatic int find_client(logic [IP_W-1:0] ip);
    for (int i = 0; i < CLIENT_SLOTS; i++) begin
      if (client_used[i] && peer_addr[i] == ip) return i;
    end
    return -1;
  endfunction

  // Works out the result of one beat and advances the mirrored state.
  function automatic result_t knock_outcome(knock_t k);
    result_t         r;
    logic [7:0]      digit;
    logic [PW_W-1:0] pw;
    logic [1:0]      code;
    logic [3:0]      codes;
    int              slot;
    r.status = STAT_OK;
    r.start  = 1'b0;
    r.ext    = '0;
    if (k.close) begin
      start_requested = 1'b0;
      r.status = STAT_CLOSED;
      return r;
    end
    digit = k.head[HEAD_W-1 -: 8];
    if (digit != DIGIT_ZERO && digit != DIGIT_ONE) begin
      r.status = STAT_BAD_DIGIT;
      return r;
    end
    // The whole password, digit included, must be new.
    pw = {k.head, k.tail};
    foreach (stored_pw[i]) begin
      if (stored_pw[i] == pw) begin
        r.status = STAT_REPLAY;
        return r;
      end
    end
    if (stored_pw.size() < REPLAY_DEPTH) stored_pw.push_back(pw);
    // Find the client, or take the lowest free entry.
    slot = find_client(k.ip);
    if (slot < 0) begin
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
        if (!client_used[i]) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        r.status = STAT_NO_SLOT;
        return r;
      end
      client_used[slot]  = 1'b1;
      peer_addr[slot]    = k.ip;
      client_codes[slot] = '0;
    end
    code  = k.port_g ? CODE_G : CODE_O;
    codes = client_codes[slot];
    if (digit == DIGIT_ZERO) codes[1:0] = code;
    else codes[3:2] = code;
    // Only second port in slot 0 and first port in slot 1 completes the sequence.
    if (codes[1:0] == CODE_G && codes[3:2] == CODE_O) begin
      client_codes[slot] = '0;
      if (!start_requested && !k.running) begin
        start_requested = 1'b1;
        r.start = 1'b1;
      end else begin
        r.ext = extension_s;
      end
    end else begin
      client_codes[slot] = codes;
    end
    return r;
  endfunction

  // Random beat. A pool index forces a fresh knock from that client.
  function automatic knock_t random_knock(int pool_pick);
    knock_t      k;
    int          kind;
    int          slot;
    logic [7:0]  digit;
    logic [3:0]  codes;
    logic [63:0] noise;
    noise     = {$urandom(), $urandom()};
    k.close   = 1'b0;
    k.ip      = ip_pool[$urandom_range(CLIENT_SLOTS-1)];
    k.port_g  = 1'($urandom_range(1));
    k.head    = $urandom();
    k.tail    = noise[TAIL_W-1:0];
    k.running = ($urandom_range(99) < 35);
    kind      = $urandom_range(99);
    if (pool_pick >= 0) begin
      k.ip = ip_pool[pool_pick];
      kind = 99;
    end
    if (kind < 6) begin
      k.close = 1'b1;
    end else if (kind < 12) begin
      do digit = 8'($urandom_range(255)); while (digit == DIGIT_ZERO || digit == DIGIT_ONE);
      k.head[HEAD_W-1 -: 8] = digit;
    end else if (kind < 20 && stored_pw.size() > 0) begin
      // Resend an earlier password, most often one that was recorded.
      if (have_last_pw && $urandom_range(1)) {k.head, k.tail} = last_pw;
      else {k.head, k.tail} = stored_pw[$urandom_range(stored_pw.size()-1)];
    end else begin
      // A stranger address shows up now and then.
      if (kind < 28) k.ip = $urandom();
      slot  = find_client(k.ip);
      codes = (slot >= 0) ? client_codes[slot] : 4'b0;
      // Mostly the move that brings this client closer to a full sequence.
      if ($urandom_range(99) < 75) begin
        if (codes[1:0] == CODE_G) begin
          digit = DIGIT_ONE;
          k.port_g = 1'b0;
        end else if (codes[3:2] == CODE_O || $urandom_range(1)) begin
          digit = DIGIT_ZERO;
          k.port_g = 1'b1;
        end else begin
          digit = DIGIT_ONE;
          k.port_g = 1'b0;
        end
      end else begin
        digit = $urandom_range(1) ? DIGIT_ONE : DIGIT_ZERO;
      end
      k.head[HEAD_W-1 -: 8] = digit;
    end
    return k;
  endfunction

  task automatic add_row(logic close, logic [IP_W-1:0] ip, logic port_g,
                         logic [HEAD_W-1:0] head, logic [TAIL_W-1:0] tail,
                         logic running, bit typed, status_e st, logic start,
                         logic [EXT_W-1:0] ext);
    script_row_t row;
    row.beat.close   = close;
    row.beat.ip      = ip;
    row.beat.port_g  = port_g;
    row.beat.head    = head;
    row.beat.tail    = tail;
    row.beat.running = running;
    row.typed        = typed;
    row.want.status  = st;
    row.want.start   = start;
    row.want.ext     = ext;
    knock_script.push_back(row);
  endtask

  // Offers one beat, after a random gap outside the steady phase, and books its result when taken.
  task automatic send_knock(knock_t k, bit typed, result_t typed_want);
    result_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k.close;
    s_axis_tdata  <= {{IN_PAD{1'b0}}, k.running, k.tail, k.head, k.port_g, k.ip};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = knock_outcome(k);
    results_due.push_back(typed ? typed_want : predicted);
    if (!k.close && (k.head[HEAD_W-1 -: 8] == DIGIT_ZERO ||
                     k.head[HEAD_W-1 -: 8] == DIGIT_ONE)) begin
      last_pw = {k.head, k.tail};
      have_last_pw = 1'b1;
    end
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  task automatic write_extension(logic [EXT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    extension_s = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random back-pressure, one long hold-off, and the check.
  always @(posedge clk_i) begin : result_check
    result_t    want;
    logic [2:0] got_status;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got_status = m_axis_tdata[2:0];
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("beat with status %0d and nothing expected",
                                    got_status));
        end else begin
          want = results_due.pop_front();
          if (got_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
          if (m_axis_tdata[3] !== want.start)
            report_mismatch($sformatf("start_server %0d, expected %0d",
                                      m_axis_tdata[3], want.start));
          if (m_axis_tdata[11:4] !== want.ext)
            report_mismatch($sformatf("extend_amount %0d, expected %0d",
                                      m_axis_tdata[11:4], want.ext));
        end
      end
      if (!holdoff_done && results_seen == HOLDOFF_AT) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end else begin
      m_axis_tready <= 1'b0;
    end
  end

  initial begin : stimulus
    result_t no_want;
    int      i;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    no_want         = '0;
    steady          = 1'b0;
    have_last_pw    = 1'b0;
    last_pw         = '0;
    start_requested = 1'b0;
    extension_s     = EXT_RESET;
    for (i = 0; i < CLIENT_SLOTS; i++) begin
      client_used[i]  = 1'b0;
      peer_addr[i]    = '0;
      client_codes[i] = '0;
      ip_pool[i]      = $urandom();
    end
    ip_pool[0] = '0;
    ip_pool[1] = '1;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats, all under the reset extension of 10 s.
    add_row(1, '1, 1, '1, '1, 1, 1, STAT_CLOSED, 0, 0);
    add_row(0, '0, 0, 32'h0000_0000, '0, 0, 1, STAT_BAD_DIGIT, 0, 0);
    add_row(0, '1, 1, 32'hFFFF_FFFF, '1, 1, 1, STAT_BAD_DIGIT, 0, 0);
    add_row(0, '0, 1, 32'h2FFF_FFFF, '0, 0, 1, STAT_BAD_DIGIT, 0, 0);
    add_row(0, '0, 0, 32'h3200_0000, '0, 0, 1, STAT_BAD_DIGIT, 0, 0);
    add_row(0, '0, 1, 32'h3000_0000, '0, 0, 1, STAT_OK, 0, 0);
    add_row(0, '0, 0, 32'h31FF_FFFF, '1, 0, 1, STAT_OK, 1, 0);
    // Same password from another address is still a replay.
    add_row(0, '1, 1, 32'h3000_0000, '0, 1, 1, STAT_REPLAY, 0, 0);
    add_row(0, '1, 0, 32'h3100_0001, 40'h1, 0, 1, STAT_OK, 0, 0);
    // Completes while a start is pending.
    add_row(0, '1, 1, 32'h30AB_CDEF, 40'h12_3456_789A, 0, 1, STAT_OK, 0, EXT_RESET);
    add_row(1, '0, 0, '0, '0, 0, 1, STAT_CLOSED, 0, 0);
    add_row(0, '1, 1, 32'h3055_AA55, 40'hAA_55AA_55AA, 1, 1, STAT_OK, 0, 0);
    // Completes while the server runs.
    add_row(0, '1, 0, 32'h31AA_55AA, 40'h55_AA55_AA55, 1, 1, STAT_OK, 0, EXT_RESET);
    // A complete pair in the wrong order is kept, then slots are overwritten.
    add_row(0, '0, 0, 32'h3012_3456, 40'h01_0203_0405, 0, 0, STAT_OK, 0, 0);
    add_row(0, '0, 1, 32'h3165_4321, 40'h06_0708_090A, 0, 0, STAT_OK, 0, 0);
    add_row(0, '0, 1, 32'h30FE_DCBA, 40'h0B_0C0D_0E0F, 0, 0, STAT_OK, 0, 0);
    add_row(0, '0, 0, 32'h3102_4681, 40'h10_1112_1314, 0, 0, STAT_OK, 0, 0);
    add_row(0, '1, 1, 32'h3102_4681, 40'h10_1112_1314, 1, 1, STAT_REPLAY, 0, 0);
    // Same tail bytes with another digit is a new password.
    add_row(0, '1, 1, 32'h3112_3456, 40'h01_0203_0405, 0, 0, STAT_OK, 0, 0);
    add_row(1, '0, 0, '0, '0, 0, 1, STAT_CLOSED, 0, 0);
    add_row(0, '1, 0, 32'h3133_3333, 40'h77_7777_7777, 0, 0, STAT_OK, 0, 0);
    add_row(0, '1, 1, 32'h30CC_CCCC, 40'h88_8888_8888, 0, 0, STAT_OK, 0, 0);
    foreach (knock_script[r])
      send_knock(knock_script[r].beat, knock_script[r].typed, knock_script[r].want);

    wait_results_drained();
    write_extension(8'hFF);
    // Enroll the rest of the client pool so that the table fills up.
    for (i = 2; i < CLIENT_SLOTS; i++) send_knock(random_knock(i), 1'b0, no_want);
    for (i = 0; i < PHASE_ITEMS; i++) begin
      steady = (i >= STEADY_FIRST && i < STEADY_LAST);
      send_knock(random_knock(-1), 1'b0, no_want);
    end
    steady = 1'b0;

    wait_results_drained();
    write_extension(8'h00);
    for (i = 0; i < PHASE_ITEMS; i++) send_knock(random_knock(-1), 1'b0, no_want);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/pkt_pkg.sv
rtl/core/port_knock_tracker.sv
sim/port_knock_tracker_tb.sv
